### rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the sorted stack: item layouts, action and
// status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package sws_pkg;

	// Stack depth and the widths that follow from it
	localparam int DEPTH   = 32;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int DATA_W   = 32;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 6;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_POP   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_TOP   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SORT  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Value returned by a pop or top read of an empty stack
	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic signed [DATA_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STATUS_W-1:0]      status;
		logic [ECOUNT_W-1:0]      entry_count;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_HOLD,
		ST_CMP,
		ST_PUT
	} seq_state_t;

endpackage

### rtl/stack_with_sort_top.sv
// ----------------------------------------------------------------------------
// stack_with_sort_top
// Fixed-depth LIFO of signed 32-bit words with push, pop, top read, clear and
// an in-place descending insertion sort, one result per command item.
// ----------------------------------------------------------------------------
// Each command item gives exactly one response item. Push, clear, sort of
// fewer than two entries, unknown actions and pop or top of an empty stack
// respond in the cycle after acceptance; pop and top with data pass through
// the store's registered read port, then the response register. Sort walks
// the store through that read port, one write port and a single signed
// comparator: for each entry i from 1 to n-1 it fetches the entry in ST_LOAD
// and ST_HOLD, moves it down one slot per ST_CMP step, and writes it to its
// slot in ST_CMP, or in ST_PUT if it reaches slot 0. No new command is taken
// while an item is in progress or while a response waits unread. Clear only
// resets the count; entries are read only after being written.
module stack_with_sort_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  sws_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sws_pkg::rsp_item_t rsp
);
	import sws_pkg::*;

	// Entry store and its ports
	logic [DATA_W-1:0] mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic [ADDR_W-1:0] mem_ra;
	logic [DATA_W-1:0] rd_q;

	// Control state
	seq_state_t         state_q, state_d;
	logic [COUNT_W-1:0] fill_q, fill_d;
	logic [ADDR_W-1:0]  i_q, i_d;
	logic [ADDR_W-1:0]  pos_q, pos_d;
	logic [DATA_W-1:0]  held_q;
	logic               held_ld;

	// Response register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	logic      res_load;
	rsp_item_t res_item;

	logic cmd_acc;
	logic empty;
	logic full;
	logic last_i;
	logic greater;

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == COUNT_W'(DEPTH));
	assign last_i  = ((COUNT_W'(i_q) + COUNT_W'(1)) == fill_q);
	assign greater = ($signed(held_q) > $signed(rd_q));

	// Take a command only when idle and the response slot will be free
	assign cmd_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd.action)
						ACT_POP, ACT_TOP: begin
							if (!empty) state_d = ST_READ;
						end
						ACT_SORT: begin
							if (fill_q > COUNT_W'(1)) state_d = ST_LOAD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_LOAD: state_d = ST_HOLD;
			ST_HOLD: state_d = ST_CMP;
			ST_CMP: begin
				if (greater) begin
					state_d = (pos_q == ADDR_W'(1)) ? ST_PUT : ST_CMP;
				end else begin
					state_d = last_i ? ST_IDLE : ST_LOAD;
				end
			end
			ST_PUT: state_d = last_i ? ST_IDLE : ST_LOAD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath controls and responses
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = '0;
		mem_ra   = ADDR_W'(fill_q - COUNT_W'(1));
		fill_d   = fill_q;
		i_d      = i_q;
		pos_d    = pos_q;
		held_ld  = 1'b0;
		res_load = 1'b0;
		res_item = '{read_value: '0, status: STAT_OK, entry_count: '0};
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					res_load = 1'b1;
					case (cmd.action)
						ACT_PUSH: begin
							if (full) begin
								res_item.status = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								mem_wa = ADDR_W'(fill_q);
								mem_wd = cmd.push_value;
								fill_d = fill_q + COUNT_W'(1);
							end
						end
						ACT_POP: begin
							if (empty) begin
								res_item.read_value = EMPTY_VALUE;
								res_item.status     = STAT_EMPTY;
							end else begin
								fill_d   = fill_q - COUNT_W'(1);
								res_load = 1'b0;
							end
						end
						ACT_TOP: begin
							if (empty) begin
								res_item.read_value = EMPTY_VALUE;
								res_item.status     = STAT_EMPTY;
							end else begin
								res_load = 1'b0;
							end
						end
						ACT_CLEAR: fill_d = '0;
						ACT_SORT: begin
							if (fill_q > COUNT_W'(1)) begin
								res_load = 1'b0;
								i_d      = ADDR_W'(1);
							end
						end
						default: fill_d = fill_q;
					endcase
					res_item.entry_count = ECOUNT_W'(fill_d);
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_item.read_value  = rd_q;
				res_item.entry_count = ECOUNT_W'(fill_q);
			end
			ST_LOAD: begin
				mem_ra = i_q;
			end
			ST_HOLD: begin
				held_ld = 1'b1;
				pos_d   = i_q;
				mem_ra  = i_q - ADDR_W'(1);
			end
			ST_CMP: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				if (greater) begin
					// shift the smaller entry up one slot and look further down
					mem_wd = rd_q;
					pos_d  = pos_q - ADDR_W'(1);
					mem_ra = pos_q - ADDR_W'(2);
				end else begin
					// drop the held entry into its slot
					mem_wd = held_q;
					i_d    = i_q + ADDR_W'(1);
					if (last_i) begin
						res_load = 1'b1;
						res_item.entry_count = ECOUNT_W'(fill_q);
					end
				end
			end
			ST_PUT: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = held_q;
				i_d    = i_q + ADDR_W'(1);
				if (last_i) begin
					res_load = 1'b1;
					res_item.entry_count = ECOUNT_W'(fill_q);
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			i_q     <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			i_q     <= i_d;
			pos_q   <= pos_d;
		end
	end

	// Hold the entry being inserted
	always_ff @(posedge clk) begin
		if (held_ld) held_q <= rd_q;
	end

	// Response register: load a finished result, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) rsp_q <= res_item;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= COUNT_W'(DEPTH))
		else $error("entry count above depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(rsp_valid_q && rsp_stall))
		else $error("response overwritten while waiting");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> cmd_stall)
		else $error("command taken while busy");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (pos_q != '0) && (pos_q <= i_q))
		else $error("insert position out of range");

	a_sort_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_HOLD || state_q == ST_CMP ||
		 state_q == ST_PUT) |=> $stable(fill_q))
		else $error("entry count changed during sort");

endmodule
